/* design/ldls_pkg.sv */
package ldls_pkg;

  localparam int WORD_BITS  = 16;
  localparam int IN_WORD_W  = 16;
  localparam int LATCH_W    = 5;
  localparam int PULSE_W    = 6;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 8;
  localparam int CNT_W      = ($clog2(WORD_BITS) > PULSE_W) ? $clog2(WORD_BITS) : PULSE_W;
  localparam int STEP_W     = 3;

  localparam logic [PULSE_W-1:0] MAX_PULSES = PULSE_W'(62);
  localparam logic [CNT_W-1:0]   WORD_LAST  = CNT_W'(WORD_BITS - 1);

  typedef enum logic [STEP_W-1:0] {
    STEP_FETCH = 3'd0,
    STEP_DATA  = 3'd1,
    STEP_HEAD  = 3'd2,
    STEP_BODY  = 3'd3,
    STEP_TAIL  = 3'd4
  } ldls_step_e;

  typedef enum logic [1:0] {
    JMP_ACTION    = 2'd0,
    JMP_CNTZ_LOOP = 2'd1,
    JMP_CNTZ_SKIP = 2'd2,
    JMP_GOTO      = 2'd3
  } ldls_jmp_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_LOAD = 2'd1,
    CNT_DEC  = 2'd2
  } ldls_cnt_e;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_LOAD = 2'd1,
    SH_LEFT = 2'd2
  } ldls_sh_e;

  typedef enum logic [1:0] {
    LE_ZERO = 2'd0,
    LE_ONE  = 2'd1,
    LE_CMP  = 2'd2
  } ldls_le_e;

  typedef enum logic [1:0] {
    LAST_ZERO = 2'd0,
    LAST_ONE  = 2'd1,
    LAST_CNTZ = 2'd2
  } ldls_last_e;

  typedef struct packed {
    logic       accept;
    logic       emit;
    logic       mosi_en;
    ldls_le_e   le_src;
    ldls_last_e last_src;
    ldls_cnt_e  cnt_op;
    ldls_sh_e   sh_op;
    ldls_jmp_e  jmp;
    ldls_step_e target;
  } ldls_uop_t;

  typedef struct packed {
    ldls_uop_t uop;
    logic      fire;
  } ldls_ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic action;
    logic slot_free;
  } ldls_stat_t;

  function automatic ldls_uop_t ucode(input ldls_step_e step);
    ldls_uop_t u;
    u = '{accept: 1'b0, emit: 1'b0, mosi_en: 1'b0, le_src: LE_ZERO, last_src: LAST_ZERO,
          cnt_op: CNT_HOLD, sh_op: SH_HOLD, jmp: JMP_GOTO, target: STEP_FETCH};
    case (step)
      STEP_FETCH: begin
        u.accept = 1'b1;
        u.cnt_op = CNT_LOAD;
        u.sh_op  = SH_LOAD;
        u.jmp    = JMP_ACTION;
        u.target = STEP_HEAD;
      end
      STEP_DATA: begin
        u.emit     = 1'b1;
        u.mosi_en  = 1'b1;
        u.le_src   = LE_CMP;
        u.last_src = LAST_CNTZ;
        u.cnt_op   = CNT_DEC;
        u.sh_op    = SH_LEFT;
        u.jmp      = JMP_CNTZ_LOOP;
        u.target   = STEP_FETCH;
      end
      STEP_HEAD: begin
        u.emit   = 1'b1;
        u.cnt_op = CNT_DEC;
        u.jmp    = JMP_CNTZ_SKIP;
        u.target = STEP_TAIL;
      end
      STEP_BODY: begin
        u.emit   = 1'b1;
        u.le_src = LE_ONE;
        u.cnt_op = CNT_DEC;
        u.jmp    = JMP_CNTZ_LOOP;
        u.target = STEP_TAIL;
      end
      STEP_TAIL: begin
        u.emit     = 1'b1;
        u.last_src = LAST_ONE;
        u.jmp      = JMP_GOTO;
        u.target   = STEP_FETCH;
      end
      default: begin
        u.jmp    = JMP_GOTO;
        u.target = STEP_FETCH;
      end
    endcase
    return u;
  endfunction

  function automatic logic [WORD_BITS-1:0] fit_word(input logic [IN_WORD_W-1:0] w);
    logic [IN_WORD_W+31:0] t;
    t = {32'd0, w};
    return t[WORD_BITS-1:0];
  endfunction

endpackage

/* design/ldls_sequencer.sv */
module ldls_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ldls_pkg::ldls_stat_t stat_i,
  output ldls_pkg::ldls_ctrl_t ctrl_o
);

  ldls_pkg::ldls_step_e step_q, step_d;
  ldls_pkg::ldls_step_e step_next;
  ldls_pkg::ldls_uop_t  uop;
  logic                 fire;

  assign uop       = ldls_pkg::ucode(step_q);
  assign step_next = ldls_pkg::ldls_step_e'(step_q + 3'd1);
  assign fire      = uop.accept ? in_valid_i : (uop.emit ? stat_i.slot_free : 1'b1);

  always_comb begin
    step_d = step_q;
    if (fire) begin
      case (uop.jmp)
        ldls_pkg::JMP_ACTION:    step_d = stat_i.action ? uop.target : step_next;
        ldls_pkg::JMP_CNTZ_LOOP: step_d = stat_i.cnt_zero ? uop.target : step_q;
        ldls_pkg::JMP_CNTZ_SKIP: step_d = stat_i.cnt_zero ? uop.target : step_next;
        ldls_pkg::JMP_GOTO:      step_d = uop.target;
        default:                 step_d = ldls_pkg::STEP_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ldls_pkg::STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = '{uop: uop, fire: fire};

endmodule

/* design/ldls_datapath.sv */
module ldls_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ldls_pkg::ldls_ctrl_t              ctrl_i,
  input  logic                              action_i,
  input  logic [ldls_pkg::IN_WORD_W-1:0]    word_i,
  input  logic [ldls_pkg::LATCH_W-1:0]      latch_bits_i,
  input  logic [ldls_pkg::PULSE_W-1:0]      pulse_count_i,
  input  logic                              out_ready_i,
  output ldls_pkg::ldls_stat_t              stat_o,
  output logic                              out_valid_o,
  output logic                              mosi_o,
  output logic                              latch_enable_o,
  output logic                              last_o
);

  logic [ldls_pkg::WORD_BITS-1:0] shift_q, shift_d;
  logic [ldls_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [ldls_pkg::LATCH_W-1:0]   latch_q, latch_d;
  logic                           vld_q, vld_d;
  logic                           mosi_q, le_q, last_q;
  logic                           mosi_d, le_d, last_d;
  logic [ldls_pkg::PULSE_W-1:0]   pulse_sat;
  logic                           cnt_zero;
  logic                           slot_free;

  assign cnt_zero  = (cnt_q == '0);
  assign slot_free = !vld_q || out_ready_i;
  assign pulse_sat = (pulse_count_i > ldls_pkg::MAX_PULSES) ? ldls_pkg::MAX_PULSES
                                                             : pulse_count_i;

  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    latch_d = latch_q;
    if (ctrl_i.fire) begin
      case (ctrl_i.uop.sh_op)
        ldls_pkg::SH_LOAD: begin
          shift_d = ldls_pkg::fit_word(word_i);
          latch_d = latch_bits_i;
        end
        ldls_pkg::SH_LEFT: shift_d = {shift_q[ldls_pkg::WORD_BITS-2:0], 1'b0};
        default:           shift_d = shift_q;
      endcase
      case (ctrl_i.uop.cnt_op)
        ldls_pkg::CNT_LOAD: cnt_d = action_i ? ldls_pkg::CNT_W'(pulse_sat)
                                             : ldls_pkg::WORD_LAST;
        ldls_pkg::CNT_DEC:  cnt_d = cnt_q - 1'b1;
        default:            cnt_d = cnt_q;
      endcase
    end
  end

  always_comb begin
    mosi_d = ctrl_i.uop.mosi_en & shift_q[ldls_pkg::WORD_BITS-1];
    case (ctrl_i.uop.le_src)
      ldls_pkg::LE_ONE: le_d = 1'b1;
      ldls_pkg::LE_CMP: le_d = (cnt_q < ldls_pkg::CNT_W'(latch_q));
      default:          le_d = 1'b0;
    endcase
    case (ctrl_i.uop.last_src)
      ldls_pkg::LAST_ONE:  last_d = 1'b1;
      ldls_pkg::LAST_CNTZ: last_d = cnt_zero;
      default:             last_d = 1'b0;
    endcase
    vld_d = vld_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (ctrl_i.fire && ctrl_i.uop.emit) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    cnt_q   <= cnt_d;
    latch_q <= latch_d;
    if (ctrl_i.fire && ctrl_i.uop.emit) begin
      mosi_q <= mosi_d;
      le_q   <= le_d;
      last_q <= last_d;
    end
  end

  assign stat_o         = '{cnt_zero: cnt_zero, action: action_i, slot_free: slot_free};
  assign out_valid_o    = vld_q;
  assign mosi_o         = mosi_q;
  assign latch_enable_o = le_q;
  assign last_o         = last_q;

endmodule

/* design/led_driver_latch_serializer_unit.sv */
// Serial encoder for a chained LED driver. Each request on the slave stream is one command
// and gives one master-stream item per serial-clock pulse (data level, latch-enable level,
// tlast on the final pulse). A data word (tuser 0) sends WORD_BITS pulses msb first with
// latch enable high on the final latch_bits pulses; a
// pulse train (tuser 1) gives a latch-low pulse, pulse_count latch-high pulses (62 at most)
// and a latch-low pulse. The microcode sequencer spends one step fetching the command and
// one step per pulse; output back-pressure stalls it. A command is taken while the last
// pulse still waits in the output register.
module led_driver_latch_serializer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] word, [20:16] latch_bits, [26:21] pulse_count, rest zero
  input  logic [ldls_pkg::S_DATA_W-1:0]    s_axis_tdata_i,
  // [0] action
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] mosi, [1] latch_enable, rest zero
  output logic [ldls_pkg::M_DATA_W-1:0]    m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  ldls_pkg::ldls_ctrl_t ctrl;
  ldls_pkg::ldls_stat_t stat;
  logic                 mosi;
  logic                 latch_enable;

  ldls_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ldls_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .action_i       (s_axis_tuser_i),
    .word_i         (s_axis_tdata_i[15:0]),
    .latch_bits_i   (s_axis_tdata_i[20:16]),
    .pulse_count_i  (s_axis_tdata_i[26:21]),
    .out_ready_i    (m_axis_tready_i),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid_o),
    .mosi_o         (mosi),
    .latch_enable_o (latch_enable),
    .last_o         (m_axis_tlast_o)
  );

  assign s_axis_tready_o = ctrl.uop.accept;
  assign m_axis_tdata_o  = {{(ldls_pkg::M_DATA_W-2){1'b0}}, latch_enable, mosi};

endmodule

/* tb/led_driver_latch_serializer_checker.sv */
`timescale 1ns / 100ps

package ldls_tb_pkg;

  typedef enum logic {
    CMD_WORD  = 1'b0,
    CMD_TRAIN = 1'b1
  } cmd_e;

endpackage

module led_driver_latch_serializer_checker
  import ldls_pkg::*;
  import ldls_tb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [S_DATA_W-1:0] s_tdata_i,
  input  logic                s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [M_DATA_W-1:0] m_tdata_i,
  input  logic                m_tlast_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct packed {
    logic mosi;
    logic le;
    logic last;
  } pulse_t;

  pulse_t pulse_q[$];
  int     request_no;
  int     pulse_no;

  initial begin
    errors_o   = 0;
    pending_o  = 0;
    request_no = 0;
    pulse_no   = 0;
  end

  task automatic report_mismatch(input string what);
    $display("checker: pulse %0d (request %0d): %s", pulse_no, request_no, what);
    errors_o++;
  endtask

  task automatic queue_pulses(input cmd_e act, input logic [IN_WORD_W-1:0] w,
                              input logic [LATCH_W-1:0] lb, input logic [PULSE_W-1:0] pc);
    int     span;
    int     pos;
    pulse_t p;
    if (act == CMD_WORD) begin
      span = (int'(lb) > WORD_BITS) ? WORD_BITS : int'(lb);
      for (pos = WORD_BITS - 1; pos >= 0; pos--) begin
        p.mosi = (pos < IN_WORD_W) ? w[pos] : 1'b0;
        p.le   = (pos < span);
        p.last = (pos == 0);
        pulse_q.push_back(p);
      end
    end else begin
      span = (pc > MAX_PULSES) ? int'(MAX_PULSES) : int'(pc);
      pulse_q.push_back(pulse_t'{1'b0, 1'b0, 1'b0});
      repeat (span) pulse_q.push_back(pulse_t'{1'b0, 1'b1, 1'b0});
      pulse_q.push_back(pulse_t'{1'b0, 1'b0, 1'b1});
    end
  endtask

  always @(posedge clk_i) begin
    pulse_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) begin
        request_no++;
        queue_pulses(cmd_e'(s_tuser_i), s_tdata_i[IN_WORD_W-1:0],
                     s_tdata_i[IN_WORD_W +: LATCH_W],
                     s_tdata_i[IN_WORD_W + LATCH_W +: PULSE_W]);
      end
      if (m_tvalid_i && m_tready_i) begin
        pulse_no++;
        if (pulse_q.size() == 0) begin
          report_mismatch("pulse with none expected");
        end else begin
          want = pulse_q.pop_front();
          if (m_tdata_i[0] !== want.mosi)
            report_mismatch($sformatf("mosi %b, expected %b", m_tdata_i[0], want.mosi));
          if (m_tdata_i[1] !== want.le)
            report_mismatch($sformatf("latch_enable %b, expected %b", m_tdata_i[1], want.le));
          if (m_tlast_i !== want.last)
            report_mismatch($sformatf("last %b, expected %b", m_tlast_i, want.last));
        end
      end
      pending_o = pulse_q.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ldls_pkg::*;
  import ldls_tb_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_CMDS  = 220;
  localparam int QUIET_FROM   = 180;
  localparam int DRAIN_CYCLES = 100;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  int errors;
  int pending;
  int idle_cycles = 0;
  int stall_left  = 0;
  int calm_left   = 0;
  bit quiet       = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  led_driver_latch_serializer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  led_driver_latch_serializer_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tlast_i  (m_tlast),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // stall the pulse sink in bursts, with calm stretches between
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (quiet || calm_left > 0) begin
      m_tready  <= 1'b1;
      calm_left <= (calm_left > 0) ? calm_left - 1 : 0;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      m_tready  <= 1'b1;
      calm_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : 0;
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  task automatic push_cmd(input cmd_e act, input logic [IN_WORD_W-1:0] w,
                          input logic [LATCH_W-1:0] lb, input logic [PULSE_W-1:0] pc);
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(S_DATA_W - IN_WORD_W - LATCH_W - PULSE_W){1'b0}}, pc, lb, w};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  initial begin
    cmd_e                 act;
    logic [IN_WORD_W-1:0] w;
    logic [LATCH_W-1:0]   lb;
    logic [PULSE_W-1:0]   pc;
    int                   pick;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    push_cmd(CMD_WORD,  16'hffff, 5'd0,  6'd0);
    push_cmd(CMD_WORD,  16'h0000, 5'd16, 6'd0);
    push_cmd(CMD_WORD,  16'h8001, 5'd1,  6'd0);
    push_cmd(CMD_WORD,  16'ha5c3, 5'd17, 6'd0);
    push_cmd(CMD_WORD,  16'h5aa5, 5'd31, 6'd63);
    push_cmd(CMD_WORD,  16'h7ffe, 5'd15, 6'd42);
    push_cmd(CMD_WORD,  16'h1234, 5'd8,  6'd0);
    push_cmd(CMD_TRAIN, 16'hffff, 5'd31, 6'd0);
    push_cmd(CMD_TRAIN, 16'h0000, 5'd0,  6'd1);
    push_cmd(CMD_TRAIN, 16'hbeef, 5'd16, 6'd3);
    push_cmd(CMD_TRAIN, 16'h0000, 5'd0,  6'd12);
    push_cmd(CMD_TRAIN, 16'h0000, 5'd0,  6'd14);
    push_cmd(CMD_TRAIN, 16'h0000, 5'd0,  6'd62);
    push_cmd(CMD_TRAIN, 16'h0000, 5'd0,  6'd63);
    push_cmd(CMD_WORD,  16'hc0de, 5'd4,  6'd0);
    push_cmd(CMD_TRAIN, 16'h00ff, 5'd2,  6'd61);
    push_cmd(CMD_WORD,  16'h0001, 5'd16, 6'd62);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      quiet = (i >= QUIET_FROM);
      act   = ($urandom_range(0, 99) < 55) ? CMD_WORD : CMD_TRAIN;
      w     = IN_WORD_W'($urandom);
      lb    = ($urandom_range(0, 9) == 0) ? LATCH_W'($urandom_range(17, 31))
                                          : LATCH_W'($urandom_range(0, 16));
      pick  = $urandom_range(0, 9);
      if (pick < 7)
        pc = PULSE_W'($urandom_range(0, 15));
      else if (pick < 9)
        pc = PULSE_W'($urandom_range(16, 61));
      else
        pc = PULSE_W'($urandom_range(62, 63));
      push_cmd(act, w, lb, pc);
      if (i == RANDOM_CMDS / 2) begin
        // drain every pulse before the next request
        hold_off(1);
        while (pending != 0) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 14));
      end
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0 && pending == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
